// ----- design/cdma_pkg.sv -----
// Shared types and constants of the four-user spread/despread unit.
// Holds the item structs, code register defaults and command codes.
// No dependencies.
`default_nettype none

package cdma_pkg;

    localparam int NUM_USERS   = 4;
    localparam int NUM_CHIPS   = 8;
    localparam int LEVEL_W     = 3;
    localparam int CHIP_WORD_W = NUM_CHIPS * LEVEL_W;
    localparam int BYTE_W      = 8;
    localparam int CFG_IDX_W   = 2;

    // Command of an input item
    localparam logic CMD_SPREAD   = 1'b0;
    localparam logic CMD_DESPREAD = 1'b1;

    // Kind of a result item
    localparam logic KIND_CHIP_WORD = 1'b0;
    localparam logic KIND_BYTES     = 1'b1;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_CODE_USER_ONE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_USER_TWO   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_USER_THREE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_USER_FOUR  = 2'd3;

    // Per-user bytes and per-user codes, index 0 is user one
    typedef logic [NUM_USERS-1:0][BYTE_W-1:0] user_bytes_t;
    typedef logic [NUM_USERS-1:0][NUM_CHIPS-1:0] codes_t;

    localparam codes_t CODE_RESET = {8'd66, 8'd58, 8'd116, 8'd216};

    typedef struct packed {
        logic                   cmd;
        logic [BYTE_W-1:0]      user_one_byte;
        logic [BYTE_W-1:0]      user_two_byte;
        logic [BYTE_W-1:0]      user_three_byte;
        logic [BYTE_W-1:0]      user_four_byte;
        logic [CHIP_WORD_W-1:0] chip_word_in;
    } in_item_t;

    typedef struct packed {
        logic                   kind;
        logic [CHIP_WORD_W-1:0] chip_word_out;
        logic                   last;
        logic [BYTE_W-1:0]      out_user_one;
        logic [BYTE_W-1:0]      out_user_two;
        logic [BYTE_W-1:0]      out_user_three;
        logic [BYTE_W-1:0]      out_user_four;
    } out_item_t;

endpackage

`default_nettype wire

// ----- design/cdma_spread_despread_unit.sv -----
// Four-user code-division spread/despread unit, top level.
// Depends on cdma_pkg, cdma_spreader and cdma_correlator.
//
// Usage:
//   Input items (in_valid/in_ready, in_data) are either a spread command with
//   four user bytes or a despread command with one 24-bit chip word.
//   Results leave on out_valid/out_ready with out_data.
//   An accepted item sits in a stage register; its first result is loaded into
//   the output register once that register is free, and out_valid rises with
//   it.
//   Spread: eight chip words, one per cycle while the output is not stalled,
//   MSB data bit first, last set on the eighth. The stage register holds the
//   item until its eighth word is loaded; only then is a new item accepted.
//   Despread: one item per cycle while the output is free. Only the eighth word
//   of a run gives a result (four recovered bytes); the others update the bit
//   accumulators. The user must write codes on cfg_we/cfg_index/cfg_wdata only
//   while the unit is idle; the unit does not enforce this. Reset: codes go to
//   their defaults, the despread run and both registers are emptied. A stalled
//   output holds its item; a stage item needing it holds, and in_ready drops.
`default_nettype none

module cdma_spread_despread_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire cdma_pkg::in_item_t                 in_data,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output cdma_pkg::out_item_t                     out_data,
    input  wire logic                               cfg_we,
    input  wire logic [cdma_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [cdma_pkg::BYTE_W-1:0]        cfg_wdata
);

    cdma_pkg::codes_t      code_reg;
    logic                  stage_valid_reg;
    cdma_pkg::in_item_t    stage_item_reg;
    logic [2:0]            chip_idx_reg;
    logic [2:0]            bit_position_reg;
    cdma_pkg::user_bytes_t recovered_reg;
    logic                  out_valid_reg;
    cdma_pkg::out_item_t   out_data_reg;

    cdma_pkg::user_bytes_t                 stage_bytes;
    cdma_pkg::user_bytes_t                 merged;
    logic [cdma_pkg::CHIP_WORD_W-1:0]      spread_word;
    logic [cdma_pkg::NUM_USERS-1:0]        despread_bits;
    logic [cdma_pkg::BYTE_W-1:0]           bit_mask;
    cdma_pkg::out_item_t                   out_next;
    logic in_accept, out_free, is_spread, run_end, needs_out, step, stage_done, out_load;

    assign stage_bytes = {stage_item_reg.user_four_byte, stage_item_reg.user_three_byte,
                          stage_item_reg.user_two_byte, stage_item_reg.user_one_byte};

    cdma_spreader u_spreader (
        .data      (stage_bytes),
        .codes     (code_reg),
        .bit_sel   (3'd7 - chip_idx_reg),
        .chip_word (spread_word)
    );

    cdma_correlator u_correlator (
        .chip_word (stage_item_reg.chip_word_in),
        .codes     (code_reg),
        .bits      (despread_bits)
    );

    // Handshake and stage control
    assign in_accept  = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign is_spread  = (stage_item_reg.cmd == cdma_pkg::CMD_SPREAD);
    assign run_end    = (bit_position_reg == 3'd7);
    assign needs_out  = is_spread || run_end;
    assign step       = stage_valid_reg && (!needs_out || out_free);
    assign stage_done = step && (!is_spread || (chip_idx_reg == 3'd7));
    assign out_load   = step && needs_out;
    assign in_ready   = !stage_valid_reg || stage_done;

    // Merge this word's bits into the accumulators
    assign bit_mask = 8'b1000_0000 >> bit_position_reg;
    always_comb
    begin
        for (int u = 0; u < cdma_pkg::NUM_USERS; u++)
        begin
            merged[u] = recovered_reg[u] | (despread_bits[u] ? bit_mask : '0);
        end
    end

    // Build the next result
    always_comb
    begin
        out_next = '0;
        if (is_spread)
        begin
            out_next.kind          = cdma_pkg::KIND_CHIP_WORD;
            out_next.chip_word_out = spread_word;
            out_next.last          = (chip_idx_reg == 3'd7);
        end
        else
        begin
            out_next.kind           = cdma_pkg::KIND_BYTES;
            out_next.out_user_one   = merged[0];
            out_next.out_user_two   = merged[1];
            out_next.out_user_three = merged[2];
            out_next.out_user_four  = merged[3];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg         <= cdma_pkg::CODE_RESET;
            stage_valid_reg  <= 1'b0;
            chip_idx_reg     <= '0;
            bit_position_reg <= '0;
            recovered_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                code_reg[cfg_index] <= cfg_wdata;
            end
            if (in_accept)
                stage_valid_reg <= 1'b1;
            else if (stage_done)
                stage_valid_reg <= 1'b0;
            // Advance the chip word index; it wraps to zero after the eighth
            if (step && is_spread)
                chip_idx_reg <= chip_idx_reg + 3'd1;
            // Advance or close the despread run
            if (step && !is_spread)
            begin
                if (run_end)
                begin
                    bit_position_reg <= '0;
                    recovered_reg    <= '0;
                end
                else
                begin
                    bit_position_reg <= bit_position_reg + 3'd1;
                    recovered_reg    <= merged;
                end
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
            stage_item_reg <= in_data;
        if (out_load)
            out_data_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A spread run in progress means the stage holds a spread item
    a_chip_idx_in_spread: assert property (@(posedge clk) disable iff (!rst_n)
        (chip_idx_reg != 3'd0) |-> (stage_valid_reg && is_spread))
        else $error("chip index advanced without a spread item in the stage");

    // A byte result closes the run and clears the accumulators
    a_run_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && !is_spread) |=> ((bit_position_reg == 3'd0) && (recovered_reg == '0)))
        else $error("despread run not cleared after byte result");

    // The stage is never dropped without having produced its results
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && needs_out && !out_free) |=> stage_valid_reg)
        else $error("stage item dropped while output was stalled");

endmodule

`default_nettype wire

// ----- design/cdma_spreader.sv -----
// Chip word builder: one data bit of each user spread over eight chips.
// Depends on cdma_pkg.
`default_nettype none

module cdma_spreader (
    input  wire cdma_pkg::user_bytes_t              data,
    input  wire cdma_pkg::codes_t                   codes,
    input  wire logic [2:0]                         bit_sel,
    output logic [cdma_pkg::CHIP_WORD_W-1:0]        chip_word
);

    // Level of a chip is the number of users whose data bit matches the chip
    always_comb
    begin
        logic [cdma_pkg::NUM_USERS-1:0] dbits;
        logic [cdma_pkg::LEVEL_W-1:0]   level;
        chip_word = '0;
        for (int u = 0; u < cdma_pkg::NUM_USERS; u++)
        begin
            dbits[u] = data[u][bit_sel];
        end
        for (int k = 0; k < cdma_pkg::NUM_CHIPS; k++)
        begin
            level = '0;
            for (int u = 0; u < cdma_pkg::NUM_USERS; u++)
            begin
                level = level + {2'b00, ~(dbits[u] ^ codes[u][k])};
            end
            chip_word[cdma_pkg::CHIP_WORD_W-1-cdma_pkg::LEVEL_W*k -: cdma_pkg::LEVEL_W] =
                level;
        end
    end

endmodule

`default_nettype wire

// ----- design/cdma_correlator.sv -----
// Despread correlator: one chip word against all four codes, one bit per user.
// Depends on cdma_pkg.
`default_nettype none

module cdma_correlator (
    input  wire logic [cdma_pkg::CHIP_WORD_W-1:0] chip_word,
    input  wire cdma_pkg::codes_t                 codes,
    output logic [cdma_pkg::NUM_USERS-1:0]        bits
);

    // Sum of +/-(2*level-4); a quotient of -1 by 8 means a sum in -15..-8
    always_comb
    begin
        logic signed [7:0]            acc;
        logic signed [5:0]            term;
        logic [cdma_pkg::LEVEL_W-1:0] lvl;
        bits = '0;
        for (int u = 0; u < cdma_pkg::NUM_USERS; u++)
        begin
            acc = '0;
            for (int k = 0; k < cdma_pkg::NUM_CHIPS; k++)
            begin
                lvl  = chip_word[cdma_pkg::CHIP_WORD_W-1-cdma_pkg::LEVEL_W*k -:
                                 cdma_pkg::LEVEL_W];
                term = $signed({2'b00, lvl, 1'b0}) - 6'sd4;
                if (codes[u][k])
                    acc = acc + {{2{term[5]}}, term};
                else
                    acc = acc - {{2{term[5]}}, term};
            end
            bits[u] = !((acc >= -8'sd15) && (acc <= -8'sd8));
        end
    end

endmodule

`default_nettype wire
